FILE: design/ecf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Euler circuit finder.
// No dependencies; imported by the top level.
package ecf_pkg;

    // Fixed port field widths
    localparam int VTX_W   = 3;
    localparam int WIN_W   = 16;
    localparam int TOTAL_W = 22;

    // Request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_RUN   = 1'b1;

    // Multiplicity saturation point
    localparam logic [1:0] MAX_MULT = 2'd2;

    // Longest run the result channel may carry
    localparam int RESULT_LIMIT = 56;

    // Register map, selected by paddr[2]
    localparam logic ADDR_START = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR2,
        ST_CP_RD,
        ST_CP_WR,
        ST_SIZE,
        ST_START,
        ST_LOADW,
        ST_SCAN,
        ST_NROW,
        ST_POP,
        ST_CHECK,
        ST_CRD,
        ST_CWT,
        ST_WT,
        ST_OUT
    } state_t;

endpackage

FILE: design/ecf_row_pick.sv
`timescale 1ns / 1ps
// Picks the lowest-numbered neighbor with an unused edge in one adjacency row.
// No package dependencies.
module ecf_row_pick #(
    parameter int VERTICES = 8,
    parameter int VBITS    = 3
) (
    input  logic [VERTICES-1:0][1:0] row,
    output logic                     found,
    output logic [VBITS-1:0]         idx
);

    // Priority search, lowest index wins
    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int i = VERTICES - 1; i >= 0; i--) begin
            if (row[i] != 2'd0) begin
                found = 1'b1;
                idx   = VBITS'(i);
            end
        end
    end

endmodule

FILE: design/euler_circuit_finder.sv
`timescale 1ns / 1ps
// Euler circuit finder top level: adjacency stores, walk and circuit stacks,
// sequencer and ports. Depends on ecf_pkg and ecf_row_pick.
//
// A write beat (req_type 0) sets both symmetric cells of the multiplicity and
// weight stores, first the addressed cell and then its mirror; diagonal or
// out-of-range cells are dropped. A run beat (req_type 1) copies the
// multiplicities into a working store organized one row per word, walks
// Hierholzer's stacks from start_vertex (the working-row and walk-stack
// memories have registered reads), then streams the circuit, with a
// circuit-store read and then a weight-store read for each edge beat. One
// item is in work at a time and s_ready is high only while idle. The
// multiplicity store clears at reset through one valid flop per cell, so no
// clearing pass is needed and the block is ready right after reset.
module euler_circuit_finder
    import ecf_pkg::*;
#(
    parameter int VERTICES    = 8,
    parameter int PATH_DEPTH  = 57,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [VTX_W-1:0]    s_row_vertex,
    input  logic [VTX_W-1:0]    s_col_vertex,
    input  logic [1:0]          s_edge_multiplicity,
    input  logic [WIN_W-1:0]    s_edge_weight_in,
    // Result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [VTX_W-1:0]    m_from_vertex,
    output logic [VTX_W-1:0]    m_to_vertex,
    output logic [WIN_W-1:0]    m_edge_weight_out,
    output logic [TOTAL_W-1:0]  m_total_weight,
    output logic                m_edge_valid,
    output logic                m_not_eulerian,
    output logic                m_last
);

    localparam int VBITS     = $clog2(VERTICES);
    localparam int CELL_BITS = 2 * VBITS;
    localparam int CELLS     = 1 << CELL_BITS;
    localparam int MAX_EDGES = VERTICES * (VERTICES - 1);
    localparam int EW        = $clog2(MAX_EDGES + 1);
    localparam int SIDX      = $clog2(PATH_DEPTH);
    localparam int SPW       = $clog2(PATH_DEPTH + 1);
    localparam logic [VBITS-1:0] LAST_V = VBITS'(VERTICES - 1);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t                     state_reg, state_next;
    logic [VTX_W-1:0]           start_reg;
    logic [CELLS-1:0]           cv_reg;

    logic [VBITS-1:0]           wr_row_reg, wr_row_next;
    logic [VBITS-1:0]           wr_col_reg, wr_col_next;
    logic [1:0]                 wr_mult_reg, wr_mult_next;
    logic [WEIGHT_BITS-1:0]     wr_wt_reg, wr_wt_next;

    logic [VBITS-1:0]           k_reg, k_next;
    logic [EW-1:0]              edges_reg, edges_next;
    logic [VBITS-1:0]           top_reg, top_next;
    logic [VBITS-1:0]           prev_reg, prev_next;
    logic [VERTICES-1:0][1:0]   cur_row_reg, cur_row_next;
    logic [SPW-1:0]             sp_reg, sp_next;
    logic [SPW-1:0]             cnt_reg, cnt_next;
    logic [SIDX-1:0]            idx_reg, idx_next;
    logic                       first_reg, first_next;
    logic [VBITS-1:0]           a_reg, a_next;
    logic [VBITS-1:0]           b_reg, b_next;

    logic                       mvalid_reg, mvalid_next;
    logic [VBITS-1:0]           out_from_reg, out_from_next;
    logic [VBITS-1:0]           out_to_reg, out_to_next;
    logic [WEIGHT_BITS-1:0]     out_w_reg, out_w_next;
    logic [TOTAL_W-1:0]         total_reg, total_next;
    logic                       out_ev_reg, out_ev_next;
    logic                       out_bad_reg, out_bad_next;
    logic                       out_last_reg, out_last_next;

    // ---------------------------------------------------------------
    // Memories and their ports
    // ---------------------------------------------------------------
    logic [VERTICES-1:0][1:0]   mult_mem [VERTICES];
    logic [WEIGHT_BITS-1:0]     wt_mem   [CELLS];
    logic [VERTICES-1:0][1:0]   work_mem [VERTICES];
    logic [VBITS-1:0]           stk_mem  [PATH_DEPTH];
    logic [VBITS-1:0]           cir_mem  [PATH_DEPTH];

    logic                       mult_we;
    logic [VBITS-1:0]           mult_wrow, mult_wcol, mult_ra;
    logic [1:0]                 mult_wd;
    logic [VERTICES-1:0][1:0]   mult_rd;

    logic                       wt_we;
    logic [CELL_BITS-1:0]       wt_wa, wt_ra;
    logic [WEIGHT_BITS-1:0]     wt_wd, wt_rd;

    logic                       work_we;
    logic [VBITS-1:0]           work_wa, work_ra;
    logic [VERTICES-1:0][1:0]   work_wd, work_rd;

    logic                       stk_we;
    logic [SIDX-1:0]            stk_wa, stk_ra;
    logic [VBITS-1:0]           stk_wd, stk_rd;

    logic                       cir_we;
    logic [SIDX-1:0]            cir_wa, cir_ra;
    logic [VBITS-1:0]           cir_wd, cir_rd;

    // ---------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------
    logic                       cfg_we;
    logic                       cv_set;
    logic [VBITS-1:0]           in_row, in_col;
    logic                       wr_ok;
    logic [1:0]                 mult_sat;
    logic [VBITS-1:0]           start_v;
    logic [VERTICES-1:0][1:0]   copy_row;
    logic [EW-1:0]              row_sum;
    logic                       pick_found;
    logic [VBITS-1:0]           pick_idx;
    logic [VERTICES-1:0][1:0]   dec_row;
    logic [VERTICES-1:0][1:0]   nbr_row;
    logic                       too_many;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;
    assign prdata = (paddr[2] == ADDR_START) ? 32'(start_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
        end else if (cfg_we && paddr[2] == ADDR_START) begin
            start_reg <= pwdata[VTX_W-1:0];
        end
    end

    // Request decode
    assign in_row   = VBITS'(s_row_vertex);
    assign in_col   = VBITS'(s_col_vertex);
    assign wr_ok    = (s_row_vertex != s_col_vertex)
                      && (32'(s_row_vertex) < VERTICES)
                      && (32'(s_col_vertex) < VERTICES);
    assign mult_sat = (s_edge_multiplicity > MAX_MULT) ? MAX_MULT : s_edge_multiplicity;
    assign start_v  = (32'(start_reg) < VERTICES) ? VBITS'(start_reg) : '0;
    assign cv_set   = (state_reg == ST_IDLE) && s_valid && (s_req_type == REQ_WRITE) && wr_ok;

    // Copy row with never-written cells read as zero; count edges above diagonal
    always_comb begin
        row_sum = '0;
        for (int j = 0; j < VERTICES; j++) begin
            copy_row[j] = cv_reg[{k_reg, VBITS'(j)}] ? mult_rd[j] : 2'd0;
            if (j > 32'(k_reg)) begin
                row_sum = row_sum + EW'(copy_row[j]);
            end
        end
    end

    assign too_many = (32'(edges_reg) + 32'd1 > PATH_DEPTH)
                      || (32'(edges_reg) > RESULT_LIMIT);

    // Neighbor search on the current row
    ecf_row_pick #(
        .VERTICES (VERTICES),
        .VBITS    (VBITS)
    ) u_pick (
        .row   (cur_row_reg),
        .found (pick_found),
        .idx   (pick_idx)
    );

    // Consume one edge on each side
    always_comb begin
        dec_row = cur_row_reg;
        dec_row[pick_idx] = cur_row_reg[pick_idx] - 2'd1;
        nbr_row = work_rd;
        nbr_row[prev_reg] = work_rd[prev_reg] - 2'd1;
    end

    // ---------------------------------------------------------------
    // Sequencer: next state, memory controls, result loading
    // ---------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        wr_row_next   = wr_row_reg;
        wr_col_next   = wr_col_reg;
        wr_mult_next  = wr_mult_reg;
        wr_wt_next    = wr_wt_reg;
        k_next        = k_reg;
        edges_next    = edges_reg;
        top_next      = top_reg;
        prev_next     = prev_reg;
        cur_row_next  = cur_row_reg;
        sp_next       = sp_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        first_next    = first_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        mvalid_next   = mvalid_reg;
        out_from_next = out_from_reg;
        out_to_next   = out_to_reg;
        out_w_next    = out_w_reg;
        total_next    = total_reg;
        out_ev_next   = out_ev_reg;
        out_bad_next  = out_bad_reg;
        out_last_next = out_last_reg;

        mult_we   = 1'b0;
        mult_wrow = '0;
        mult_wcol = '0;
        mult_wd   = '0;
        mult_ra   = k_reg;
        wt_we     = 1'b0;
        wt_wa     = '0;
        wt_wd     = '0;
        wt_ra     = '0;
        work_we   = 1'b0;
        work_wa   = '0;
        work_wd   = '0;
        work_ra   = '0;
        stk_we    = 1'b0;
        stk_wa    = '0;
        stk_wd    = '0;
        stk_ra    = '0;
        cir_we    = 1'b0;
        cir_wa    = '0;
        cir_wd    = '0;
        cir_ra    = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == REQ_RUN) begin
                        k_next     = '0;
                        edges_next = '0;
                        state_next = ST_CP_RD;
                    end else if (wr_ok) begin
                        mult_we      = 1'b1;
                        mult_wrow    = in_row;
                        mult_wcol    = in_col;
                        mult_wd      = mult_sat;
                        wt_we        = 1'b1;
                        wt_wa        = {in_row, in_col};
                        wt_wd        = WEIGHT_BITS'(s_edge_weight_in);
                        wr_row_next  = in_row;
                        wr_col_next  = in_col;
                        wr_mult_next = mult_sat;
                        wr_wt_next   = WEIGHT_BITS'(s_edge_weight_in);
                        state_next   = ST_WR2;
                    end
                end
            end

            // Mirror cell
            ST_WR2: begin
                mult_we    = 1'b1;
                mult_wrow  = wr_col_reg;
                mult_wcol  = wr_row_reg;
                mult_wd    = wr_mult_reg;
                wt_we      = 1'b1;
                wt_wa      = {wr_col_reg, wr_row_reg};
                wt_wd      = wr_wt_reg;
                state_next = ST_IDLE;
            end

            ST_CP_RD: begin
                mult_ra    = k_reg;
                state_next = ST_CP_WR;
            end

            ST_CP_WR: begin
                work_we    = 1'b1;
                work_wa    = k_reg;
                work_wd    = copy_row;
                edges_next = edges_reg + row_sum;
                if (k_reg == LAST_V) begin
                    state_next = ST_SIZE;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_CP_RD;
                end
            end

            // Reject graphs too large for the stacks or the result stream
            ST_SIZE: begin
                if (too_many) begin
                    mvalid_next   = 1'b1;
                    out_from_next = '0;
                    out_to_next   = '0;
                    out_w_next    = '0;
                    total_next    = '0;
                    out_ev_next   = 1'b0;
                    out_bad_next  = 1'b1;
                    out_last_next = 1'b1;
                    state_next    = ST_OUT;
                end else begin
                    state_next = ST_START;
                end
            end

            ST_START: begin
                stk_we     = 1'b1;
                stk_wa     = '0;
                stk_wd     = start_v;
                sp_next    = SPW'(1);
                cnt_next   = '0;
                top_next   = start_v;
                work_ra    = start_v;
                state_next = ST_LOADW;
            end

            ST_LOADW: begin
                cur_row_next = work_rd;
                state_next   = ST_SCAN;
            end

            ST_SCAN: begin
                if (pick_found && 32'(sp_reg) < PATH_DEPTH) begin
                    // Take edge top -> pick, push pick
                    work_we    = 1'b1;
                    work_wa    = top_reg;
                    work_wd    = dec_row;
                    stk_we     = 1'b1;
                    stk_wa     = SIDX'(sp_reg);
                    stk_wd     = pick_idx;
                    sp_next    = sp_reg + 1'b1;
                    work_ra    = pick_idx;
                    prev_next  = top_reg;
                    top_next   = pick_idx;
                    state_next = ST_NROW;
                end else begin
                    // Retire top to the circuit store
                    if (32'(cnt_reg) < PATH_DEPTH) begin
                        cir_we   = 1'b1;
                        cir_wa   = SIDX'(cnt_reg);
                        cir_wd   = top_reg;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    sp_next = sp_reg - 1'b1;
                    if (sp_reg == SPW'(1)) begin
                        state_next = ST_CHECK;
                    end else begin
                        stk_ra     = SIDX'(sp_reg - SPW'(2));
                        state_next = ST_POP;
                    end
                end
            end

            // Reverse side of the edge just taken
            ST_NROW: begin
                work_we      = 1'b1;
                work_wa      = top_reg;
                work_wd      = nbr_row;
                cur_row_next = nbr_row;
                state_next   = ST_SCAN;
            end

            ST_POP: begin
                top_next   = stk_rd;
                work_ra    = stk_rd;
                state_next = ST_LOADW;
            end

            ST_CHECK: begin
                total_next = '0;
                if (32'(cnt_reg) != 32'(edges_reg) + 32'd1 || edges_reg == '0) begin
                    // Unvisited edges, or the empty graph
                    mvalid_next   = 1'b1;
                    out_from_next = '0;
                    out_to_next   = '0;
                    out_w_next    = '0;
                    out_ev_next   = 1'b0;
                    out_bad_next  = (32'(cnt_reg) != 32'(edges_reg) + 32'd1);
                    out_last_next = 1'b1;
                    state_next    = ST_OUT;
                end else begin
                    idx_next   = SIDX'(edges_reg);
                    first_next = 1'b1;
                    state_next = ST_CRD;
                end
            end

            ST_CRD: begin
                cir_ra     = idx_reg;
                state_next = ST_CWT;
            end

            ST_CWT: begin
                if (first_reg) begin
                    a_next     = cir_rd;
                    first_next = 1'b0;
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_CRD;
                end else begin
                    b_next     = cir_rd;
                    wt_ra      = {a_reg, cir_rd};
                    state_next = ST_WT;
                end
            end

            ST_WT: begin
                mvalid_next   = 1'b1;
                out_from_next = a_reg;
                out_to_next   = b_reg;
                out_w_next    = wt_rd;
                total_next    = total_reg + TOTAL_W'(wt_rd);
                out_ev_next   = 1'b1;
                out_bad_next  = 1'b0;
                out_last_next = (idx_reg == '0);
                state_next    = ST_OUT;
            end

            ST_OUT: begin
                if (mvalid_reg && m_ready) begin
                    mvalid_next = 1'b0;
                    if (out_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        a_next     = b_reg;
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_CRD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
            sp_reg     <= '0;
            cnt_reg    <= '0;
            cv_reg     <= '0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            sp_reg     <= sp_next;
            cnt_reg    <= cnt_next;
            if (cv_set) begin
                cv_reg[{in_row, in_col}] <= 1'b1;
                cv_reg[{in_col, in_row}] <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        wr_row_reg   <= wr_row_next;
        wr_col_reg   <= wr_col_next;
        wr_mult_reg  <= wr_mult_next;
        wr_wt_reg    <= wr_wt_next;
        k_reg        <= k_next;
        edges_reg    <= edges_next;
        top_reg      <= top_next;
        prev_reg     <= prev_next;
        cur_row_reg  <= cur_row_next;
        idx_reg      <= idx_next;
        first_reg    <= first_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        out_from_reg <= out_from_next;
        out_to_reg   <= out_to_next;
        out_w_reg    <= out_w_next;
        total_reg    <= total_next;
        out_ev_reg   <= out_ev_next;
        out_bad_reg  <= out_bad_next;
        out_last_reg <= out_last_next;
    end

    // ---------------------------------------------------------------
    // Memories, one write and one registered read each
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mult_we) begin
            mult_mem[mult_wrow][mult_wcol] <= mult_wd;
        end
        mult_rd <= mult_mem[mult_ra];
    end

    always_ff @(posedge aclk) begin
        if (wt_we) begin
            wt_mem[wt_wa] <= wt_wd;
        end
        wt_rd <= wt_mem[wt_ra];
    end

    always_ff @(posedge aclk) begin
        if (work_we) begin
            work_mem[work_wa] <= work_wd;
        end
        work_rd <= work_mem[work_ra];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_wa] <= stk_wd;
        end
        stk_rd <= stk_mem[stk_ra];
    end

    always_ff @(posedge aclk) begin
        if (cir_we) begin
            cir_mem[cir_wa] <= cir_wd;
        end
        cir_rd <= cir_mem[cir_ra];
    end

    // Ports
    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = mvalid_reg;
    assign m_from_vertex     = VTX_W'(out_from_reg);
    assign m_to_vertex       = VTX_W'(out_to_reg);
    assign m_edge_weight_out = WIN_W'(out_w_reg);
    assign m_total_weight    = total_reg;
    assign m_edge_valid      = out_ev_reg;
    assign m_not_eulerian    = out_bad_reg;
    assign m_last            = out_last_reg;

endmodule

FILE: test/euler_circuit_finder_tb.sv
`timescale 1ns / 1ps
// Testbench for euler_circuit_finder: graph loads and circuit searches, directed then
// random, with each result beat checked against a predictor kept in the bench.
// Depends on ecf_pkg and the design sources under design/.
module euler_circuit_finder_tb;
    import ecf_pkg::*;

    localparam int N_VTX       = 8;
    localparam int STACK_DEPTH = 57;
    localparam int CYCLE_LIMIT = 1500000;
    localparam logic [2:0] START_ADDR = {ADDR_START, 2'b00};

    // One result beat, field order matches the m_ port concatenation below
    typedef struct packed {
        logic [2:0]  from_vtx;
        logic [2:0]  to_vtx;
        logic [15:0] weight;
        logic [21:0] total;
        logic        edge_ok;
        logic        bad;
        logic        last;
    } circuit_beat_t;

    // Predictor of the graph store and the circuit walk, plus the expected beat queue
    class euler_scoreboard;
        logic [1:0]    mult_q [N_VTX][N_VTX];
        logic [15:0]   wt_q [N_VTX][N_VTX];
        bit            wt_set [N_VTX][N_VTX];
        logic [2:0]    start_vtx;
        logic [2:0]    trail [STACK_DEPTH];
        circuit_beat_t expected_beats [$];
        int            errors;

        function new();
            for (int i = 0; i < N_VTX; i++)
                for (int j = 0; j < N_VTX; j++) begin
                    mult_q[i][j] = '0;
                    wt_q[i][j]   = '0;
                    wt_set[i][j] = 1'b0;
                end
            start_vtx = '0;
            errors    = 0;
        endfunction

        function int count_edges();
            int n;
            n = 0;
            for (int i = 0; i < N_VTX; i++)
                for (int j = i + 1; j < N_VTX; j++)
                    n += int'(mult_q[i][j]);
            return n;
        endfunction

        // Hierholzer walk on a copy of the counts; fills trail, returns retired vertices
        function int trace_circuit();
            logic [1:0] work [N_VTX][N_VTX];
            logic [2:0] walk [STACK_DEPTH];
            int sp, cnt, v, nxt;
            for (int i = 0; i < N_VTX; i++)
                for (int j = 0; j < N_VTX; j++)
                    work[i][j] = mult_q[i][j];
            walk[0] = start_vtx;
            sp  = 1;
            cnt = 0;
            while (sp > 0) begin
                v   = int'(walk[sp-1]);
                nxt = N_VTX;
                for (int i = 0; i < N_VTX; i++)
                    if (nxt == N_VTX && work[v][i] != 0) nxt = i;
                if (nxt < N_VTX && sp < STACK_DEPTH) begin
                    work[v][nxt]--;
                    work[nxt][v]--;
                    walk[sp] = 3'(nxt);
                    sp++;
                end else begin
                    if (cnt < STACK_DEPTH) begin
                        trail[cnt] = 3'(v);
                        cnt++;
                    end
                    sp--;
                end
            end
            return cnt;
        endfunction

        // Finds a weight cell the next search would read before it was ever written
        function bit blank_weight(output int ra, output int rb);
            int edges, cnt, a, b;
            ra = 0;
            rb = 0;
            edges = count_edges();
            if (edges == 0 || edges + 1 > STACK_DEPTH || edges > RESULT_LIMIT) return 1'b0;
            cnt = trace_circuit();
            if (cnt != edges + 1) return 1'b0;
            for (int e = 0; e < edges; e++) begin
                a = int'(trail[edges-e]);
                b = int'(trail[edges-1-e]);
                if (!wt_set[a][b]) begin
                    ra = a;
                    rb = b;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void predict_search();
            circuit_beat_t bt;
            logic [21:0] total;
            int edges, cnt, a, b;
            bt    = '0;
            total = '0;
            edges = count_edges();
            if (edges + 1 > STACK_DEPTH || edges > RESULT_LIMIT) cnt = -1;
            else cnt = trace_circuit();
            if (cnt != edges + 1) begin
                // edges left unused, or over the stack or result limit: single failure beat
                bt.bad  = 1'b1;
                bt.last = 1'b1;
                expected_beats.push_back(bt);
            end else if (edges == 0) begin
                bt.last = 1'b1;
                expected_beats.push_back(bt);
            end else begin
                for (int e = 0; e < edges; e++) begin
                    a = int'(trail[edges-e]);
                    b = int'(trail[edges-1-e]);
                    total = total + 22'(wt_q[a][b]);
                    bt.from_vtx = 3'(a);
                    bt.to_vtx   = 3'(b);
                    bt.weight   = wt_q[a][b];
                    bt.total    = total;
                    bt.edge_ok  = 1'b1;
                    bt.bad      = 1'b0;
                    bt.last     = (e + 1 == edges);
                    expected_beats.push_back(bt);
                end
            end
        endfunction

        // Called for every accepted request beat
        function void note_request(logic req, logic [2:0] row, logic [2:0] col,
                                   logic [1:0] mult, logic [15:0] w);
            logic [1:0] m;
            if (req == REQ_RUN) begin
                predict_search();
                return;
            end
            m = (mult > MAX_MULT) ? MAX_MULT : mult;
            if (row != col) begin
                mult_q[row][col] = m;
                mult_q[col][row] = m;
                wt_q[row][col]   = w;
                wt_q[col][row]   = w;
                wt_set[row][col] = 1'b1;
                wt_set[col][row] = 1'b1;
            end
        endfunction

        function void compare_field(string label, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, label, want, seen);
            end
        endfunction

        // Called for every accepted result beat
        function void check_beat(circuit_beat_t got);
            circuit_beat_t want;
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t: result beat expected none, got from %0d to %0d total %0d last %0d",
                         $time, got.from_vtx, got.to_vtx, got.total, got.last);
                return;
            end
            want = expected_beats.pop_front();
            compare_field("from_vertex", 32'(want.from_vtx), 32'(got.from_vtx));
            compare_field("to_vertex", 32'(want.to_vtx), 32'(got.to_vtx));
            compare_field("edge_weight_out", 32'(want.weight), 32'(got.weight));
            compare_field("total_weight", 32'(want.total), 32'(got.total));
            compare_field("edge_valid", 32'(want.edge_ok), 32'(got.edge_ok));
            compare_field("not_eulerian", 32'(want.bad), 32'(got.bad));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_req_type = REQ_WRITE;
    logic [VTX_W-1:0]   s_row_vertex = '0;
    logic [VTX_W-1:0]   s_col_vertex = '0;
    logic [1:0]         s_edge_multiplicity = '0;
    logic [WIN_W-1:0]   s_edge_weight_in = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [VTX_W-1:0]   m_from_vertex;
    logic [VTX_W-1:0]   m_to_vertex;
    logic [WIN_W-1:0]   m_edge_weight_out;
    logic [TOTAL_W-1:0] m_total_weight;
    logic               m_edge_valid;
    logic               m_not_eulerian;
    logic               m_last;

    euler_scoreboard tracker = new();
    int              src_idle_pct = 0;
    int              sink_idle_pct = 0;
    int              items_sent = 0;
    int              cycle_count = 0;
    logic [2:0]      start_reg = '0;

    euler_circuit_finder dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_req_type          (s_req_type),
        .s_row_vertex        (s_row_vertex),
        .s_col_vertex        (s_col_vertex),
        .s_edge_multiplicity (s_edge_multiplicity),
        .s_edge_weight_in    (s_edge_weight_in),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_from_vertex       (m_from_vertex),
        .m_to_vertex         (m_to_vertex),
        .m_edge_weight_out   (m_edge_weight_out),
        .m_total_weight      (m_total_weight),
        .m_edge_valid        (m_edge_valid),
        .m_not_eulerian      (m_not_eulerian),
        .m_last              (m_last)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result sink: random stalls, check every accepted beat
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_beat({m_from_vertex, m_to_vertex, m_edge_weight_out,
                                m_total_weight, m_edge_valid, m_not_eulerian, m_last});
        m_ready <= aresetn && ($urandom_range(99) >= sink_idle_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("euler_circuit_finder_tb: errors");
            $finish;
        end
    end

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Drive one request beat; valid stays up from the last beat unless a gap is drawn
    task automatic send_request(input logic req, input logic [2:0] row, input logic [2:0] col,
                                input logic [1:0] mult, input logic [15:0] w);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_req_type          <= req;
        s_row_vertex        <= row;
        s_col_vertex        <= col;
        s_edge_multiplicity <= mult;
        s_edge_weight_in    <= w;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(req, row, col, mult, w);
        if (req == REQ_RUN || row != col) items_sent++;
    endtask

    // Write one undirected cell in a random orientation
    task automatic write_pair(input int a, input int b, input logic [1:0] mult,
                              input logic [15:0] w);
        if ($urandom_range(1) != 0) send_request(REQ_WRITE, 3'(a), 3'(b), mult, w);
        else send_request(REQ_WRITE, 3'(b), 3'(a), mult, w);
    endtask

    // Start a search; first give a weight to any cell it would read unwritten
    task automatic launch_search();
        int a, b;
        while (tracker.blank_weight(a, b))
            write_pair(a, b, tracker.mult_q[a][b], pick_weight());
        send_request(REQ_RUN, 3'($urandom_range(7)), 3'($urandom_range(7)),
                     2'($urandom_range(3)), pick_weight());
    endtask

    // Stop sending and wait until every expected beat is in and the block is idle
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.expected_beats.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // APB write of start_vertex, then read it back
    task automatic program_start(input logic [2:0] v);
        logic [31:0] word;
        word      = $urandom;
        word[2:0] = v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= START_ADDR;
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.start_vtx = v;
        start_reg = v;
        @(posedge aclk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.compare_field("start_vertex readback", 32'(v), 32'(prdata[2:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Remove every edge
    task automatic clear_graph();
        for (int i = 0; i < N_VTX; i++)
            for (int j = i + 1; j < N_VTX; j++)
                if (tracker.mult_q[i][j] != 0) write_pair(i, j, 2'd0, pick_weight());
    endtask

    // Complete graph with doubled edges: the longest circuit
    task automatic dense_graph(input bit max_weights);
        for (int i = 0; i < N_VTX; i++)
            for (int j = i + 1; j < N_VTX; j++)
                write_pair(i, j, MAX_MULT, max_weights ? 16'hFFFF : pick_weight());
    endtask

    // Add a random closed loop of 2..6 vertices; keeps degrees even
    task automatic add_loop();
        int ord [N_VTX];
        logic [1:0] grown [N_VTX][N_VTX];
        int len, j, t, a, b;
        bit fits;
        for (int i = 0; i < N_VTX; i++) ord[i] = i;
        for (int i = N_VTX - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = ord[i];
            ord[i] = ord[j];
            ord[j] = t;
        end
        // usually through the start vertex so the graph stays reachable
        if ($urandom_range(3) != 0)
            for (int i = 0; i < N_VTX; i++)
                if (ord[i] == int'(start_reg)) begin
                    ord[i] = ord[0];
                    ord[0] = int'(start_reg);
                end
        len = $urandom_range(2, 6);
        for (int i = 0; i < N_VTX; i++)
            for (int k = 0; k < N_VTX; k++)
                grown[i][k] = tracker.mult_q[i][k];
        fits = 1'b1;
        for (int i = 0; i < len; i++) begin
            a = ord[i];
            b = ord[(i + 1) % len];
            if (grown[a][b] >= MAX_MULT) fits = 1'b0;
            else begin
                grown[a][b]++;
                grown[b][a]++;
            end
        end
        if (!fits) return;
        for (int i = 0; i < N_VTX; i++)
            for (int k = i + 1; k < N_VTX; k++)
                if (grown[i][k] != tracker.mult_q[i][k])
                    write_pair(i, k, grown[i][k], pick_weight());
    endtask

    // One random graph edit followed by a search
    task automatic random_episode();
        int pick, n;
        pick = $urandom_range(99);
        if (pick < 4) begin
            dense_graph(1'($urandom_range(1)));
        end else if (pick < 30) begin
            clear_graph();
            n = $urandom_range(1, 3);
            repeat (n) add_loop();
        end else if (pick < 70) begin
            add_loop();
        end else begin
            // raw writes: odd degrees, diagonal cells, saturating counts
            n = $urandom_range(1, 3);
            repeat (n)
                send_request(REQ_WRITE, 3'($urandom_range(7)), 3'($urandom_range(7)),
                             2'($urandom_range(3)), pick_weight());
        end
        launch_search();
    endtask

    // Main sequence
    initial begin
        int goal;
        src_idle_pct  = 12;
        sink_idle_pct = 58;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        program_start(3'd0);

        // empty graph, ignored diagonal, triangle
        launch_search();
        send_request(REQ_WRITE, 3'd3, 3'd3, 2'd2, 16'hFFFF);
        send_request(REQ_WRITE, 3'd1, 3'd0, 2'd1, 16'h0000);
        send_request(REQ_WRITE, 3'd1, 3'd2, 2'd1, 16'hFFFF);
        send_request(REQ_WRITE, 3'd0, 3'd2, 2'd1, 16'h1234);
        launch_search();
        // count of three saturates to a double edge
        send_request(REQ_WRITE, 3'd3, 3'd2, 2'd3, 16'hFFFF);
        launch_search();
        // unreachable edge: not Eulerian
        send_request(REQ_WRITE, 3'd5, 3'd6, 2'd1, 16'h00FF);
        launch_search();
        // odd-degree path that the walk still covers
        send_request(REQ_WRITE, 3'd6, 3'd5, 2'd0, 16'hA5A5);
        send_request(REQ_WRITE, 3'd2, 3'd1, 2'd0, 16'h5A5A);
        send_request(REQ_WRITE, 3'd2, 3'd3, 2'd0, 16'h8001);
        launch_search();
        settle();

        // top start vertex: isolated first, then joined by a double edge
        program_start(3'd7);
        launch_search();
        send_request(REQ_WRITE, 3'd7, 3'd0, 2'd2, 16'hFFFF);
        launch_search();

        // random part in three idling phases, start vertex changed per chunk
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 12;
                    sink_idle_pct = 58;
                end
                1: begin
                    src_idle_pct  = 58;
                    sink_idle_pct = 12;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int chunk = 0; chunk < 2; chunk++) begin
                settle();
                program_start(3'($urandom_range(7)));
                if (phase == 0 && chunk == 0) begin
                    dense_graph(1'b1);
                    launch_search();
                end
                goal = items_sent + 50;
                while (items_sent < goal) random_episode();
            end
        end

        settle();
        repeat (32) @(posedge aclk);
        if (tracker.errors == 0 && tracker.expected_beats.size() == 0)
            $display("euler_circuit_finder_tb: clean");
        else
            $display("euler_circuit_finder_tb: errors");
        $finish;
    end

endmodule
